>>> rtl/ofr_pkg.sv
// ----------------------------------------------------------------------------
// ofr_pkg
// Shared widths, defaults, seed table and pipeline context type for the
// orbit-frame to Cartesian rotation unit.
// ----------------------------------------------------------------------------
package ofr_pkg;

   localparam int AXIS_FRAC_BITS_DEF = 30;
   localparam int RSQRT_STEPS_DEF    = 4;

   localparam int POS_W = 38;
   localparam int VEL_W = 26;
   localparam int OFF_W = 31;
   localparam int OUT_W = 32;
   localparam int VEC_W = 64;
   localparam int MAG_W = 30;
   localparam int RS_W  = 32;
   localparam int EX_W  = 6;

   // register depth of the unit, from its input register to its axis register
   function automatic int unit_latency(input int steps);
      return 8 + 3 * steps;
   endfunction

   // Q2.30 start value of 1/sqrt, indexed by the top four bits of the normalized norm
   function automatic logic [RS_W-1:0] rsq_seed(input logic [3:0] top);
      logic [16:0] q;
      case (top)
         4'd4:    q = 17'd123576;
         4'd5:    q = 17'd111779;
         4'd6:    q = 17'd102821;
         4'd7:    q = 17'd95721;
         4'd8:    q = 17'd89915;
         4'd9:    q = 17'd85051;
         4'd10:   q = 17'd80899;
         4'd11:   q = 17'd77302;
         4'd12:   q = 17'd74146;
         4'd13:   q = 17'd71347;
         4'd14:   q = 17'd68842;
         4'd15:   q = 17'd66585;
         default: q = '0;
      endcase
      return RS_W'({q, 14'b0});
   endfunction

   typedef struct packed {
      logic [RS_W-1:0]             x32;
      logic [EX_W-1:0]             ex;
      logic [2:0][MAG_W-1:0]       mag;
      logic [2:0]                  sgn;
   } ofr_ctx_type;

endpackage

>>> rtl/ofr_unitize.sv
// ----------------------------------------------------------------------------
// ofr_unitize
// Pipelined unit-vector unit: scale down, squared norm, normalize,
// Newton reciprocal square root, then scale each component.
// ----------------------------------------------------------------------------
module ofr_unitize #(
   parameter int AXIS_FRAC_BITS = ofr_pkg::AXIS_FRAC_BITS_DEF,
   parameter int RSQRT_STEPS    = ofr_pkg::RSQRT_STEPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic signed [ofr_pkg::VEC_W-1:0]      vec_in   [3],
   output logic signed [AXIS_FRAC_BITS+2:0]      axis_out [3]
);
   import ofr_pkg::*;

   localparam int AW = AXIS_FRAC_BITS + 3;
   localparam int NW = 2 * MAG_W + 2;
   localparam logic [RS_W-1:0] THREE_HALF = RS_W'(64'd3 << 30);

   // stage 1: magnitudes
   logic [VEC_W-1:0] mag1_in  [3];
   logic [VEC_W-1:0] mag1_ff  [3];
   logic [2:0]       sg1_ff;
   logic [VEC_W-1:0] mor1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag1_in[i] = vec_in[i][VEC_W-1] ? VEC_W'(-vec_in[i]) : VEC_W'(vec_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mag1_ff[i] <= mag1_in[i];
            sg1_ff[i]  <= vec_in[i][VEC_W-1];
         end
         // the or of the magnitudes has the same top bit as their maximum
         mor1_ff <= mag1_in[0] | mag1_in[1] | mag1_in[2];
      end
   end

   // stage 2: scale down below 2^30
   logic [6:0]       top1;
   logic [5:0]       sft2;
   logic [MAG_W-1:0] mag2_in [3];
   logic [MAG_W-1:0] mag2_ff [3];
   logic [2:0]       sg2_ff;

   always_comb begin
      top1 = '0;
      for (int b = 0; b < VEC_W; b++) begin
         if (mor1_ff[b]) top1 = 7'(b);
      end
      sft2 = (top1 >= 7'd30) ? 6'(top1 - 7'd29) : '0;
      for (int i = 0; i < 3; i++) begin
         mag2_in[i] = MAG_W'(mag1_ff[i] >> sft2);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag2_ff <= mag2_in;
         sg2_ff  <= sg1_ff;
      end
   end

   // stage 3: squares
   logic [2*MAG_W-1:0] sq3_ff  [3];
   logic [MAG_W-1:0]   mag3_ff [3];
   logic [2:0]         sg3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq3_ff[i] <= (2*MAG_W)'(mag2_ff[i]) * (2*MAG_W)'(mag2_ff[i]);
         end
         mag3_ff <= mag2_ff;
         sg3_ff  <= sg2_ff;
      end
   end

   // stage 4: squared norm
   logic [NW-1:0]    n4_ff;
   logic [MAG_W-1:0] mag4_ff [3];
   logic [2:0]       sg4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         n4_ff   <= NW'(sq3_ff[0]) + NW'(sq3_ff[1]) + NW'(sq3_ff[2]);
         mag4_ff <= mag3_ff;
         sg4_ff  <= sg3_ff;
      end
   end

   // stage 5: even left shift until the norm reaches 2^60
   logic [6:0]       top4;
   logic [6:0]       dist4;
   logic [EX_W-1:0]  ex5_in;
   logic [NW-1:0]    nn5_ff;
   logic [EX_W-1:0]  ex5_ff;
   logic [MAG_W-1:0] mag5_ff [3];
   logic [2:0]       sg5_ff;

   always_comb begin
      top4 = '0;
      for (int b = 0; b < NW; b++) begin
         if (n4_ff[b]) top4 = 7'(b);
      end
      dist4  = 7'd60 - top4;
      ex5_in = (top4 >= 7'd60) ? '0 : EX_W'(dist4 + 7'(dist4[0]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nn5_ff  <= n4_ff << ex5_in;
         ex5_ff  <= ex5_in;
         mag5_ff <= mag4_ff;
         sg5_ff  <= sg4_ff;
      end
   end

   // stage 6: seed lookup, then the newton steps
   logic [RS_W-1:0] y_ff   [RSQRT_STEPS+1];
   ofr_ctx_type     ctx_ff [RSQRT_STEPS+1];
   logic [RS_W-1:0] ya_ff  [RSQRT_STEPS];
   logic [RS_W-1:0] ta_ff  [RSQRT_STEPS];
   ofr_ctx_type     ca_ff  [RSQRT_STEPS];
   logic [RS_W-1:0] yb_ff  [RSQRT_STEPS];
   logic [RS_W-1:0] ub_ff  [RSQRT_STEPS];
   ofr_ctx_type     cb_ff  [RSQRT_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff[0]       <= rsq_seed(nn5_ff[NW-1:NW-4]);
         ctx_ff[0].x32 <= nn5_ff[NW-1:NW-RS_W];
         ctx_ff[0].ex  <= ex5_ff;
         for (int i = 0; i < 3; i++) begin
            ctx_ff[0].mag[i] <= mag5_ff[i];
         end
         ctx_ff[0].sgn <= sg5_ff;
      end
   end

   for (genvar k = 0; k < RSQRT_STEPS; k++) begin : g_step
      logic [2*RS_W-1:0] sq;
      logic [2*RS_W-1:0] pu;
      logic [2*RS_W-1:0] ph;
      logic [RS_W-1:0]   h;

      always_comb begin
         sq = (2*RS_W)'(y_ff[k]) * (2*RS_W)'(y_ff[k]);
         pu = (2*RS_W)'(ca_ff[k].x32) * (2*RS_W)'(ta_ff[k]);
         h  = (ub_ff[k] >= THREE_HALF) ? '0 : THREE_HALF - ub_ff[k];
         ph = (2*RS_W)'(yb_ff[k]) * (2*RS_W)'(h);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ta_ff[k]    <= RS_W'(sq >> 30);
            ya_ff[k]    <= y_ff[k];
            ca_ff[k]    <= ctx_ff[k];
            ub_ff[k]    <= RS_W'(pu >> 32);
            yb_ff[k]    <= ya_ff[k];
            cb_ff[k]    <= ca_ff[k];
            y_ff[k+1]   <= RS_W'(ph >> 31);
            ctx_ff[k+1] <= cb_ff[k];
         end
      end
   end

   // scale each magnitude by the reciprocal norm
   logic [MAG_W+RS_W-1:0] pm_ff [3];
   ofr_ctx_type           cp_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pm_ff[i] <= (MAG_W+RS_W)'(ctx_ff[RSQRT_STEPS].mag[i]) *
                        (MAG_W+RS_W)'(y_ff[RSQRT_STEPS]);
         end
         cp_ff <= ctx_ff[RSQRT_STEPS];
      end
   end

   // final rounding shift and sign
   logic signed [AW-1:0] axis_in [3];
   logic signed [AW-1:0] axis_ff [3];

   always_comb begin
      int              sh;
      logic [63:0]     pw;
      logic [AW-1:0]   ra;
      sh = 61 - AXIS_FRAC_BITS - int'(cp_ff.ex >> 1);
      for (int i = 0; i < 3; i++) begin
         pw = 64'(pm_ff[i]);
         if (sh > 0) begin
            pw = (pw + (64'd1 << (sh - 1))) >> sh;
         end else if (sh < 0) begin
            pw = pw << (-sh);
         end
         ra         = AW'(pw);
         axis_in[i] = cp_ff.sgn[i] ? -signed'(ra) : signed'(ra);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         axis_ff <= axis_in;
      end
   end

   assign axis_out = axis_ff;

endmodule

>>> rtl/orbit_frame_to_cartesian_rotation_unit.sv
// Throughput: one item per cycle; the whole pipeline advances together and holds
// while a finished result waits on rsp_ready.
// Reset: synchronous, clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
// orbit_frame_to_cartesian_rotation_unit
// Builds radial, along-track and cross-track unit axes from position and
// velocity and rotates an orbit-frame offset into Cartesian x, y, z.
// ----------------------------------------------------------------------------
module orbit_frame_to_cartesian_rotation_unit #(
   parameter int AXIS_FRAC_BITS = ofr_pkg::AXIS_FRAC_BITS_DEF,
   parameter int RSQRT_STEPS    = ofr_pkg::RSQRT_STEPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [ofr_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [ofr_pkg::POS_W-1:0]   req_pos_y,
   input  logic signed [ofr_pkg::POS_W-1:0]   req_pos_z,
   input  logic signed [ofr_pkg::VEL_W-1:0]   req_vel_x,
   input  logic signed [ofr_pkg::VEL_W-1:0]   req_vel_y,
   input  logic signed [ofr_pkg::VEL_W-1:0]   req_vel_z,
   input  logic signed [ofr_pkg::OFF_W-1:0]   req_radial_offset,
   input  logic signed [ofr_pkg::OFF_W-1:0]   req_along_offset,
   input  logic signed [ofr_pkg::OFF_W-1:0]   req_cross_offset,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [ofr_pkg::OUT_W-1:0]   rsp_out_x,
   output logic signed [ofr_pkg::OUT_W-1:0]   rsp_out_y,
   output logic signed [ofr_pkg::OUT_W-1:0]   rsp_out_z,
   output logic                               rsp_degenerate
);
   import ofr_pkg::*;

   localparam int UL  = unit_latency(RSQRT_STEPS);
   localparam int NST = UL + 7;
   localparam int AW  = AXIS_FRAC_BITS + 3;
   localparam int PR  = 2 * AW;
   localparam int QW  = AW + OFF_W;
   localparam int OW  = QW + 2;

   localparam logic [PR:0]   RHALF = (PR+1)'(1) << (AXIS_FRAC_BITS - 1);
   localparam logic [PR:0]   RLIM  = (PR+1)'(1) << (AXIS_FRAC_BITS + 1);
   localparam logic [OW-1:0] OHALF = OW'(1) << (AXIS_FRAC_BITS - 1);
   localparam logic [OW-1:0] OLIM  = OW'(32'h7FFF_FFFF);

   logic en;
   logic vld_ff [NST];

   assign en        = !vld_ff[NST-1] || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < NST; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // stage a: cross product partial products
   logic signed [VEC_W-1:0] pa_in [6];
   logic signed [VEC_W-1:0] pa_ff [6];
   logic signed [VEL_W-1:0] va_ff [3];
   logic signed [OFF_W-1:0] oa_ff [3];

   always_comb begin
      pa_in[0] = VEC_W'(req_pos_y) * VEC_W'(req_vel_z);
      pa_in[1] = VEC_W'(req_pos_z) * VEC_W'(req_vel_y);
      pa_in[2] = VEC_W'(req_pos_z) * VEC_W'(req_vel_x);
      pa_in[3] = VEC_W'(req_pos_x) * VEC_W'(req_vel_z);
      pa_in[4] = VEC_W'(req_pos_x) * VEC_W'(req_vel_y);
      pa_in[5] = VEC_W'(req_pos_y) * VEC_W'(req_vel_x);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff    <= pa_in;
         va_ff[0] <= req_vel_x;
         va_ff[1] <= req_vel_y;
         va_ff[2] <= req_vel_z;
         oa_ff[0] <= req_radial_offset;
         oa_ff[1] <= req_along_offset;
         oa_ff[2] <= req_cross_offset;
      end
   end

   // stage b: cross product and degenerate check
   logic signed [VEC_W-1:0] cb_in [3];
   logic signed [VEC_W-1:0] cb_ff [3];
   logic signed [VEC_W-1:0] vb_ff [3];
   logic signed [OFF_W-1:0] ob_ff [3];
   logic                    degb_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cb_in[i] = pa_ff[2*i] - pa_ff[2*i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cb_ff <= cb_in;
         for (int i = 0; i < 3; i++) begin
            vb_ff[i] <= VEC_W'(va_ff[i]);
         end
         ob_ff   <= oa_ff;
         degb_ff <= (va_ff[0] == '0 && va_ff[1] == '0 && va_ff[2] == '0) ||
                    (cb_in[0] == '0 && cb_in[1] == '0 && cb_in[2] == '0);
      end
   end

   // axis units, offsets and flag ride alongside
   logic signed [AW-1:0] al_u [3];
   logic signed [AW-1:0] cr_u [3];

   ofr_unitize #(
      .AXIS_FRAC_BITS (AXIS_FRAC_BITS),
      .RSQRT_STEPS    (RSQRT_STEPS)
   ) u_along (
      .clock    (clock),
      .en       (en),
      .vec_in   (vb_ff),
      .axis_out (al_u)
   );

   ofr_unitize #(
      .AXIS_FRAC_BITS (AXIS_FRAC_BITS),
      .RSQRT_STEPS    (RSQRT_STEPS)
   ) u_cross (
      .clock    (clock),
      .en       (en),
      .vec_in   (cb_ff),
      .axis_out (cr_u)
   );

   logic signed [OFF_W-1:0] od_ff [UL][3];
   logic                    dd_ff [UL];

   always_ff @(posedge clock) begin
      if (en) begin
         od_ff[0] <= ob_ff;
         dd_ff[0] <= degb_ff;
         for (int k = 1; k < UL; k++) begin
            od_ff[k] <= od_ff[k-1];
            dd_ff[k] <= dd_ff[k-1];
         end
      end
   end

   // radial axis: along x cross, products then rounding
   logic signed [PR-1:0]    rp_ff [6];
   logic signed [AW-1:0]    al1_ff [3];
   logic signed [AW-1:0]    cr1_ff [3];
   logic signed [OFF_W-1:0] o1_ff [3];
   logic                    d1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rp_ff[0] <= PR'(al_u[1]) * PR'(cr_u[2]);
         rp_ff[1] <= PR'(al_u[2]) * PR'(cr_u[1]);
         rp_ff[2] <= PR'(al_u[2]) * PR'(cr_u[0]);
         rp_ff[3] <= PR'(al_u[0]) * PR'(cr_u[2]);
         rp_ff[4] <= PR'(al_u[0]) * PR'(cr_u[1]);
         rp_ff[5] <= PR'(al_u[1]) * PR'(cr_u[0]);
         al1_ff   <= al_u;
         cr1_ff   <= cr_u;
         o1_ff    <= od_ff[UL-1];
         d1_ff    <= dd_ff[UL-1];
      end
   end

   logic signed [AW-1:0]    ra2_in [3];
   logic signed [AW-1:0]    ra2_ff [3];
   logic signed [AW-1:0]    al2_ff [3];
   logic signed [AW-1:0]    cr2_ff [3];
   logic signed [OFF_W-1:0] o2_ff [3];
   logic                    d2_ff;

   always_comb begin
      logic signed [PR:0] rdif;
      logic [PR:0]        rmag;
      logic [PR:0]        rq;
      for (int i = 0; i < 3; i++) begin
         rdif = (PR+1)'(rp_ff[2*i]) - (PR+1)'(rp_ff[2*i+1]);
         rmag = rdif[PR] ? -rdif : rdif;
         rq   = (rmag + RHALF) >> AXIS_FRAC_BITS;
         if (rq > RLIM) rq = RLIM;
         ra2_in[i] = rdif[PR] ? -signed'(AW'(rq)) : signed'(AW'(rq));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ra2_ff <= ra2_in;
         al2_ff <= al1_ff;
         cr2_ff <= cr1_ff;
         o2_ff  <= o1_ff;
         d2_ff  <= d1_ff;
      end
   end

   // rotation: nine products, three sums, round and saturate
   logic signed [QW-1:0] op_ff [9];
   logic                 d3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            op_ff[3*i]   <= QW'(ra2_ff[i]) * QW'(o2_ff[0]);
            op_ff[3*i+1] <= QW'(al2_ff[i]) * QW'(o2_ff[1]);
            op_ff[3*i+2] <= QW'(cr2_ff[i]) * QW'(o2_ff[2]);
         end
         d3_ff <= d2_ff;
      end
   end

   logic signed [OW-1:0] sm_ff [3];
   logic                 d4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sm_ff[i] <= OW'(op_ff[3*i]) + OW'(op_ff[3*i+1]) + OW'(op_ff[3*i+2]);
         end
         d4_ff <= d3_ff;
      end
   end

   logic signed [OUT_W-1:0] out_in [3];
   logic signed [OUT_W-1:0] out_ff [3];
   logic                    deg_ff;

   always_comb begin
      logic [OW-1:0] omag;
      logic [OW-1:0] oq;
      for (int i = 0; i < 3; i++) begin
         omag = sm_ff[i][OW-1] ? -sm_ff[i] : sm_ff[i];
         oq   = (omag + OHALF) >> AXIS_FRAC_BITS;
         if (oq > OLIM) oq = OLIM;
         out_in[i] = sm_ff[i][OW-1] ? -signed'(OUT_W'(oq)) : signed'(OUT_W'(oq));
         // degenerate frame gives a fixed zero result
         if (d4_ff) out_in[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
         deg_ff <= d4_ff;
      end
   end

   assign rsp_valid      = vld_ff[NST-1];
   assign rsp_out_x      = out_ff[0];
   assign rsp_out_y      = out_ff[1];
   assign rsp_out_z      = out_ff[2];
   assign rsp_degenerate = deg_ff;

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0)
      else $error("degenerate item with nonzero output");

   a_sym_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_x != 32'sh8000_0000 && rsp_out_y != 32'sh8000_0000 &&
                    rsp_out_z != 32'sh8000_0000)
      else $error("output saturation not symmetric");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

>>> tb/orbit_frame_to_cartesian_rotation_unit_tb.sv
// ----------------------------------------------------------------------------
// orbit_frame_to_cartesian_rotation_unit_tb
// Drives position, velocity and orbit-frame offset items into the rotation
// unit and checks every returned Cartesian offset against a typed value or a
// bit-exact fixed-point predictor: directed corner rows first, then random
// orbits, with random gaps on both handshakes and one long output hold-off.
// ----------------------------------------------------------------------------
module orbit_frame_to_cartesian_rotation_unit_tb;
   import ofr_pkg::*;

   localparam int FRAC  = AXIS_FRAC_BITS_DEF;
   localparam int STEPS = RSQRT_STEPS_DEF;
   localparam int NUM_RANDOM = 500;
   localparam int LATENCY = 15 + 3 * STEPS;

   typedef struct {
      logic signed [POS_W-1:0] pos [3];
      logic signed [VEL_W-1:0] vel [3];
      logic signed [OFF_W-1:0] off [3];
   } orbit_item_type;

   typedef struct {
      logic signed [OUT_W-1:0] xyz [3];
      logic                    degenerate;
   } cart_offset_type;

   typedef struct {
      orbit_item_type  item;
      bit              typed;
      cart_offset_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic rsp_ready = 1'b0;
   logic req_ready, rsp_valid, rsp_degenerate;
   logic signed [POS_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [VEL_W-1:0] req_vel_x = '0, req_vel_y = '0, req_vel_z = '0;
   logic signed [OFF_W-1:0] req_radial_offset = '0, req_along_offset = '0;
   logic signed [OFF_W-1:0] req_cross_offset = '0;
   logic signed [OUT_W-1:0] rsp_out_x, rsp_out_y, rsp_out_z;

   cart_offset_type expected_offsets[$];
   int  error_count = 0;
   int  result_count = 0;
   int  degenerate_count = 0;
   bit  stimulus_done = 0;
   bit  hold_off = 0;

   orbit_frame_to_cartesian_rotation_unit dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [31:0] seed_q16(input int idx);
      case (idx)
         4: return 123576;   5: return 111779;   6: return 102821;
         7: return 95721;    8: return 89915;    9: return 85051;
         10: return 80899;   11: return 77302;   12: return 74146;
         13: return 71347;   14: return 68842;   15: return 66585;
         default: return 0;
      endcase
   endfunction

   // round half away from zero after a right shift, saturate to +-lim
   function automatic logic signed [63:0] round_sat(input logic signed [127:0] w,
                                                    input int k,
                                                    input logic [63:0] lim);
      logic [127:0] m;
      logic         neg;
      neg = w[127];
      m = neg ? 128'(-w) : 128'(w);
      m = (m + (128'd1 << (k - 1))) >> k;
      if (m > {64'd0, lim})
         m = {64'd0, lim};
      return neg ? -$signed(m[63:0]) : $signed(m[63:0]);
   endfunction

   function automatic void unit_axis(input logic signed [63:0] c [3],
                                     output logic signed [63:0] u [3]);
      logic [63:0] m [3];
      logic [63:0] mx, n, x32, y, t, v, h, p;
      int s, e, sh;
      mx = 0; n = 0; s = 0; e = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = c[i] < 0 ? 64'(-c[i]) : 64'(c[i]);
         if (m[i] > mx) mx = m[i];
      end
      while ((mx >> s) >= (64'd1 << 30)) s++;
      for (int i = 0; i < 3; i++) begin
         m[i] = m[i] >> s;
         n += m[i] * m[i];
      end
      while (n < (64'd1 << 60)) begin
         n = n << 2;
         e += 2;
      end
      x32 = n >> 30;
      y = 64'(seed_q16(int'(n >> 58))) << 14;
      for (int i = 0; i < STEPS; i++) begin
         t = (y * y) >> 30;
         v = (x32 * t) >> 32;
         h = (v >= (64'd3 << 30)) ? 64'd0 : (64'd3 << 30) - v;
         y = (y * h) >> 31;
      end
      sh = 61 - FRAC - e / 2;
      for (int i = 0; i < 3; i++) begin
         p = m[i] * y;
         if (sh > 0) p = (p + (64'd1 << (sh - 1))) >> sh;
         else if (sh < 0) p = p << -sh;
         u[i] = c[i] < 0 ? -$signed(p) : $signed(p);
      end
   endfunction

   function automatic cart_offset_type rotate_to_cartesian(input orbit_item_type it);
      cart_offset_type res;
      logic signed [63:0] r [3], v [3], o [3], c [3], al [3], cr [3], ra [3];
      logic signed [127:0] acc;
      for (int i = 0; i < 3; i++) begin
         r[i] = it.pos[i];
         v[i] = it.vel[i];
         o[i] = it.off[i];
      end
      c[0] = r[1] * v[2] - r[2] * v[1];
      c[1] = r[2] * v[0] - r[0] * v[2];
      c[2] = r[0] * v[1] - r[1] * v[0];
      if ((v[0] == 0 && v[1] == 0 && v[2] == 0) || (c[0] == 0 && c[1] == 0 && c[2] == 0)) begin
         res.xyz = '{0, 0, 0};
         res.degenerate = 1'b1;
         return res;
      end
      unit_axis(v, al);
      unit_axis(c, cr);
      for (int i = 0; i < 3; i++) begin
         int j, k;
         j = (i + 1) % 3;
         k = (i + 2) % 3;
         acc = 128'(al[j]) * 128'(cr[k]) - 128'(al[k]) * 128'(cr[j]);
         ra[i] = round_sat(acc, FRAC, 64'd1 << (FRAC + 1));
      end
      for (int i = 0; i < 3; i++) begin
         acc = 128'(ra[i]) * 128'(o[0]) + 128'(al[i]) * 128'(o[1])
             + 128'(cr[i]) * 128'(o[2]);
         res.xyz[i] = OUT_W'(round_sat(acc, FRAC, 64'h7FFF_FFFF));
      end
      res.degenerate = 1'b0;
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic logic signed [63:0] rand_signed(input int w);
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return 64'($signed(raw << (64 - w)) >>> (64 - w));
   endfunction

   function automatic logic signed [63:0] rand_range(input longint lim);
      longint mag;
      mag = longint'({$urandom, $urandom} % (lim + 1));
      return $urandom_range(1) ? -mag : mag;
   endfunction

   function automatic orbit_item_type random_orbit();
      orbit_item_type it;
      int mode;
      mode = $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
         if (mode == 0) begin
            // full field width, outside the stated ranges
            it.pos[i] = POS_W'(rand_signed(POS_W));
            it.vel[i] = VEL_W'(rand_signed(VEL_W));
            it.off[i] = OFF_W'(rand_signed(OFF_W));
         end else if (mode == 1) begin
            // small vectors: tiny norms, often degenerate
            it.pos[i] = POS_W'(rand_range(3));
            it.vel[i] = VEL_W'(rand_range(2));
            it.off[i] = OFF_W'(rand_range(1000));
         end else begin
            it.pos[i] = POS_W'(rand_range(64'sd100_000_000_000));
            it.vel[i] = VEL_W'(rand_range(20_000_000));
            it.off[i] = OFF_W'(rand_range(1_000_000_000));
         end
      end
      if (mode == 2) begin
         // velocity parallel to position
         for (int i = 0; i < 3; i++) it.pos[i] = POS_W'(64'(it.vel[i]) * 3);
      end
      return it;
   endfunction

   function automatic orbit_item_type make_item(input longint px, py, pz, vx, vy, vz,
                                                input longint ro, ao, co);
      orbit_item_type it;
      it.pos = '{POS_W'(px), POS_W'(py), POS_W'(pz)};
      it.vel = '{VEL_W'(vx), VEL_W'(vy), VEL_W'(vz)};
      it.off = '{OFF_W'(ro), OFF_W'(ao), OFF_W'(co)};
      return it;
   endfunction

   // idle gaps drop valid only when the gap is actually taken
   task automatic random_gap(input int pct_idle);
      int n;
      if ($urandom_range(99) >= pct_idle) return;
      n = ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(3, 1);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic send_item(input orbit_item_type it);
      req_pos_x <= it.pos[0]; req_pos_y <= it.pos[1]; req_pos_z <= it.pos[2];
      req_vel_x <= it.vel[0]; req_vel_y <= it.vel[1]; req_vel_z <= it.vel[2];
      req_radial_offset <= it.off[0];
      req_along_offset  <= it.off[1];
      req_cross_offset  <= it.off[2];
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   initial begin
      stim_row_type rows[$];
      orbit_item_type it;
      cart_offset_type z, cart;
      longint PMAX, VMAX, OMAX;
      PMAX = 64'sh1F_FFFF_FFFF;
      VMAX = 64'sh1FF_FFFF;
      OMAX = 64'sh3FFF_FFFF;
      z.xyz = '{0, 0, 0};
      z.degenerate = 1'b1;
      // zero velocity, parallel vectors and zero position are degenerate
      rows.push_back('{make_item(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, z});
      rows.push_back('{make_item(PMAX, PMAX, PMAX, 0, 0, 0, OMAX, OMAX, OMAX), 1, z});
      rows.push_back('{make_item(0, 0, 0, VMAX, 5, -3, 7, 8, 9), 1, z});
      rows.push_back('{make_item(2, 4, 6, 1, 2, 3, -OMAX - 1, 1, 1), 1, z});
      rows.push_back('{make_item(-PMAX - 1, 0, 0, -VMAX - 1, 0, 0, 5, 5, 5), 1, z});
      // circular orbit in the xy plane: radial to x, along to y, cross to z
      cart.xyz = '{100, 200, 300};
      cart.degenerate = 1'b0;
      rows.push_back('{make_item(64'sd7_000_000_000, 0, 0, 0, 7_500_000, 0, 100, 200, 300),
                       1, cart});
      rows.push_back('{make_item(0, 0, 1000, 1, 0, 0, 1, 1, 1), 0, cart});
      rows.push_back('{make_item(PMAX, -PMAX - 1, PMAX, VMAX, -VMAX - 1, 1,
                                 OMAX, -OMAX - 1, OMAX), 0, cart});
      rows.push_back('{make_item(-PMAX - 1, PMAX, 1, -VMAX - 1, -VMAX - 1, VMAX,
                                 -OMAX - 1, -OMAX - 1, -OMAX - 1), 0, cart});
      rows.push_back('{make_item(1, 0, 0, 0, 1, 0, OMAX, OMAX, OMAX), 0, cart});
      rows.push_back('{make_item(64'sd100_000_000_000, -64'sd100_000_000_000,
                                 64'sd100_000_000_000,
                                 20_000_000, 20_000_000, -20_000_000,
                                 1_000_000_000, -1_000_000_000, 1_000_000_000), 0, cart});
      rows.push_back('{make_item(-1, -1, 0, 1, -1, 1, -1, 0, 1), 0, cart});
      rows.push_back('{make_item(64'sd6_500_000_000, 1_200_000_000, -300_000_000,
                                 -1_000_000, 7_200_000, 900_000, 12345, -6789, 42), 0, cart});

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (rows[i]) begin
         expected_offsets.push_back(rows[i].typed ? rows[i].want
                                                  : rotate_to_cartesian(rows[i].item));
         send_item(rows[i].item);
         random_gap(30);
      end
      for (int i = 0; i < NUM_RANDOM; i++) begin
         it = random_orbit();
         expected_offsets.push_back(rotate_to_cartesian(it));
         send_item(it);
         // stretches of back-to-back items keep valid high
         if ((i / 60) % 2 == 1) begin
            random_gap(40);
         end
      end
      req_valid <= 1'b0;
      stimulus_done = 1;
   end

   // ---------------------------------------------------------------- receiver
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) rsp_ready <= 1'b0;
         else if ((result_count / 80) % 2 == 0) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(99) < 65);
         @(negedge clock);
      end
   end

   // long output stall so the pipeline fills and backpressures its input
   initial begin
      wait (result_count == 150);
      hold_off = 1;
      repeat (3 * LATENCY + 40) @(posedge clock);
      hold_off = 0;
   end

   always @(posedge clock) begin
      cart_offset_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (rsp_degenerate) degenerate_count++;
         if (expected_offsets.size() == 0) begin
            $display("%0t: result with nothing expected: x=%0d y=%0d z=%0d deg=%0b",
                     $time, rsp_out_x, rsp_out_y, rsp_out_z, rsp_degenerate);
            error_count++;
         end else begin
            want = expected_offsets.pop_front();
            if (rsp_out_x !== want.xyz[0]) begin
               $display("%0t: out_x expected %0d actual %0d", $time, want.xyz[0], rsp_out_x);
               error_count++;
            end
            if (rsp_out_y !== want.xyz[1]) begin
               $display("%0t: out_y expected %0d actual %0d", $time, want.xyz[1], rsp_out_y);
               error_count++;
            end
            if (rsp_out_z !== want.xyz[2]) begin
               $display("%0t: out_z expected %0d actual %0d", $time, want.xyz[2], rsp_out_z);
               error_count++;
            end
            if (rsp_degenerate !== want.degenerate) begin
               $display("%0t: degenerate expected %0b actual %0b",
                        $time, want.degenerate, rsp_degenerate);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- end of run
   initial begin
      wait (stimulus_done);
      wait (expected_offsets.size() == 0);
      repeat (2 * LATENCY + 10) @(posedge clock);
      $display("covered %0d rotated offsets, %0d of them degenerate,", result_count,
               degenerate_count);
      $display("with random gaps on both sides and one long output stall");
      if (error_count == 0)
         $display("orbit_frame_to_cartesian_rotation_unit verification clean");
      else
         $display("orbit_frame_to_cartesian_rotation_unit verification failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d items outstanding", expected_offsets.size());
      $display("orbit_frame_to_cartesian_rotation_unit verification failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/ofr_pkg.sv
rtl/ofr_unitize.sv
rtl/orbit_frame_to_cartesian_rotation_unit.sv
tb/orbit_frame_to_cartesian_rotation_unit_tb.sv
